@@ design/zeck_pkg.sv @@
package zeck_pkg;

    // Widths of the fixed payload fields.
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int INDEX_W = 6;

    // At most this many results leave for one value: one count and 23 terms.
    localparam int RESULT_LIMIT = 24;
    localparam int BUF_DEPTH    = RESULT_LIMIT - 1;
    localparam int BUF_AW       = $clog2(BUF_DEPTH);

    // Highest sequence index that a 64-bit value can need.
    localparam int FIB_MAX_INDEX = 92;

    // Result kinds.
    localparam logic KIND_COUNT = 1'b0;
    localparam logic KIND_TERM  = 1'b1;

    // Handshake and class of the item at the head of the queue.
    typedef struct packed {
        logic valid;
        logic zero;
    } q_ctl_t;

    // Sequence value at an index, with index 0 and index 1 both one.
    function automatic logic [63:0] fib_at(input int idx);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] t;
        a = 64'd1;
        b = 64'd1;
        for (int i = 2; i <= idx; i++) begin
            t = a + b;
            a = b;
            b = t;
        end
        return b;
    endfunction

    // Largest index whose sequence value still fits in a value of the given width.
    function automatic int fib_top(input int bits);
        logic [64:0] lim;
        int          top;
        lim = (65'd1 << bits) - 65'd1;
        top = 1;
        for (int i = 2; i <= FIB_MAX_INDEX; i++) begin
            if ({1'b0, fib_at(i)} <= lim) begin
                top = i;
            end
        end
        return top;
    endfunction

endpackage

@@ design/zeckendorf_decomposer.sv @@
// Order: m_valid rises with the count result after the scan of an accepted value (none for a
// zero value); the scan steps one sequence index per cycle from the top index (46 at 32 bits)
// down to the last term found. The term results follow one per cycle when the output is not
// stalled.
// Values: the single scan engine finishes one value and all its results before it takes the
// next; a two-entry queue takes new values meanwhile.
// Reset: aresetn is synchronous and active low; it empties the queue and the output.
module zeckendorf_decomposer #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [zeck_pkg::VALUE_W-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_kind,
    output logic [zeck_pkg::COUNT_W-1:0] m_term_count,
    output logic [zeck_pkg::INDEX_W-1:0] m_fib_index,
    output logic                         m_last
);
    import zeck_pkg::*;

    q_ctl_t                q_ctl;
    logic [VALUE_BITS-1:0] q_value;
    logic                  q_pop;

    // Front end: accept, mask and classify values into the queue.
    zeck_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .q_ctl  (q_ctl),
        .q_value(q_value),
        .q_pop  (q_pop)
    );

    // Back end: greedy scan and result streaming.
    zeck_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_ctl       (q_ctl),
        .q_value     (q_value),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_term_count(m_term_count),
        .m_fib_index (m_fib_index),
        .m_last      (m_last)
    );

endmodule

@@ design/zeck_front.sv @@
module zeck_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [zeck_pkg::VALUE_W-1:0] s_value,
    output zeck_pkg::q_ctl_t             q_ctl,
    output logic [VALUE_BITS-1:0]        q_value,
    input  logic                         q_pop
);
    import zeck_pkg::*;

    logic [VALUE_BITS-1:0] val_in;
    logic                  s_fire;

    logic [VALUE_BITS-1:0] val_mem_reg [2];
    logic                  zero_mem_reg [2];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            cnt_reg, cnt_next;

    // Keep only the low VALUE_BITS bits of the incoming value, or zero-extend it when wider.
    generate
        if (VALUE_BITS <= VALUE_W) begin : g_narrow
            assign val_in = s_value[VALUE_BITS-1:0];
        end else begin : g_wide
            assign val_in = {{(VALUE_BITS-VALUE_W){1'b0}}, s_value};
        end
    endgenerate

    assign s_ready = (cnt_reg != 2'd2);
    assign s_fire  = s_valid && s_ready;

    // Two-entry queue toward the scan engine.
    assign q_ctl.valid = (cnt_reg != 2'd0);
    assign q_ctl.zero  = zero_mem_reg[rd_ptr_reg];
    assign q_value     = val_mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (s_fire) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (s_fire && !q_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!s_fire && q_pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the accepted value together with its zero class.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            val_mem_reg[wr_ptr_reg]  <= val_in;
            zero_mem_reg[wr_ptr_reg] <= (val_in == '0);
        end
    end

endmodule

@@ design/zeck_back.sv @@
module zeck_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  zeck_pkg::q_ctl_t             q_ctl,
    input  logic [VALUE_BITS-1:0]        q_value,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_kind,
    output logic [zeck_pkg::COUNT_W-1:0] m_term_count,
    output logic [zeck_pkg::INDEX_W-1:0] m_fib_index,
    output logic                         m_last
);
    import zeck_pkg::*;

    localparam int          TOP    = fib_top(VALUE_BITS);
    localparam logic [63:0] FIB_HI = fib_at(TOP);
    localparam logic [63:0] FIB_LO = fib_at(TOP - 1);
    localparam int          IDX_W  = $clog2(TOP + 1);
    localparam int          CNT_W  = $clog2(TOP + 2);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] fa_reg, fa_next;
    logic [VALUE_BITS-1:0] fb_reg, fb_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      nterms_reg, nterms_next;
    logic [BUF_AW-1:0]     k_reg, k_next;
    logic [BUF_AW-1:0]     lastk_reg, lastk_next;
    logic [INDEX_W-1:0]    term_buf_reg [BUF_DEPTH];

    logic                  m_valid_reg, m_valid_next;
    logic                  m_kind_reg;
    logic [COUNT_W-1:0]    m_term_count_reg;
    logic [INDEX_W-1:0]    m_fib_index_reg;
    logic                  m_last_reg;

    logic                  take;
    logic [VALUE_BITS-1:0] rem_sub;
    logic                  buf_wr;
    logic                  out_free;
    logic                  out_load;
    logic [BUF_AW-1:0]     rd_idx;
    logic                  is_last;

    // One scan step compares the remainder with the current sequence value.
    assign take     = (fa_reg <= rem_reg);
    assign rem_sub  = rem_reg - fa_reg;
    assign buf_wr   = (state_reg == ST_SCAN) && take
                      && (32'(nterms_reg) < 32'(BUF_DEPTH));
    assign q_pop    = (state_reg == ST_IDLE) && q_ctl.valid;

    // Output register is free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_EMIT) && out_free;
    assign rd_idx   = (k_reg == '0) ? '0 : k_reg - BUF_AW'(1);
    assign is_last  = (k_reg == lastk_reg);

    // Sequencer: take a value, scan the sequence downward unless it is zero, then stream results.
    always_comb begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        fa_next     = fa_reg;
        fb_next     = fb_reg;
        idx_next    = idx_reg;
        nterms_next = nterms_reg;
        k_next      = k_reg;
        lastk_next  = lastk_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_ctl.valid) begin
                    nterms_next = '0;
                    k_next      = '0;
                    if (q_ctl.zero) begin
                        lastk_next = '0;
                        state_next = ST_EMIT;
                    end else begin
                        rem_next   = q_value;
                        fa_next    = FIB_HI[VALUE_BITS-1:0];
                        fb_next    = FIB_LO[VALUE_BITS-1:0];
                        idx_next   = IDX_W'(TOP);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (take) begin
                    rem_next    = rem_sub;
                    nterms_next = nterms_reg + CNT_W'(1);
                end
                fa_next  = fb_reg;
                fb_next  = fa_reg - fb_reg;
                idx_next = idx_reg - IDX_W'(1);
                if ((idx_reg == IDX_W'(1)) || (take && (rem_sub == '0))) begin
                    if (32'(nterms_next) >= 32'(BUF_DEPTH)) begin
                        lastk_next = BUF_AW'(BUF_DEPTH);
                    end else begin
                        lastk_next = BUF_AW'(nterms_next);
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    k_next = k_reg + BUF_AW'(1);
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid follows loads and downstream acceptance.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers of the scan.
    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        fa_reg     <= fa_next;
        fb_reg     <= fb_next;
        idx_reg    <= idx_next;
        nterms_reg <= nterms_next;
        k_reg      <= k_next;
        lastk_reg  <= lastk_next;
    end

    // Term buffer keeps the first indices found, in descending order.
    always_ff @(posedge aclk) begin
        if (buf_wr) begin
            term_buf_reg[BUF_AW'(nterms_reg)] <= INDEX_W'(idx_reg);
        end
    end

    // Result payload: the count first, then the buffered terms.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_last_reg <= is_last;
            if (k_reg == '0) begin
                m_kind_reg       <= KIND_COUNT;
                m_term_count_reg <= COUNT_W'(nterms_reg);
                m_fib_index_reg  <= '0;
            end else begin
                m_kind_reg       <= KIND_TERM;
                m_term_count_reg <= '0;
                m_fib_index_reg  <= term_buf_reg[rd_idx];
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_term_count = m_term_count_reg;
    assign m_fib_index  = m_fib_index_reg;
    assign m_last       = m_last_reg;

endmodule

@@ design/zeck_checker.sv @@
module zeck_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_kind,
    input logic [zeck_pkg::COUNT_W-1:0] m_term_count,
    input logic [zeck_pkg::INDEX_W-1:0] m_fib_index,
    input logic                         m_last
);
    import zeck_pkg::*;

    logic first_reg, first_next;

    // Tracks whether the next result opens a new value's group.
    always_comb begin
        first_next = first_reg;
        if (m_valid && m_ready) begin
            first_next = m_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else begin
            first_reg <= first_next;
        end
    end

    // Reset leaves the result channel empty.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_term_count)
            && $stable(m_fib_index) && $stable(m_last))
        else $error("stalled result changed");

    // Each group opens with a count result, and only there.
    a_group_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_kind == KIND_COUNT) == first_reg))
        else $error("count result out of place");

    // Fields that do not belong to the result kind read as zero.
    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_kind == KIND_COUNT) ? (m_fib_index == '0) : (m_term_count == '0)))
        else $error("unused result field not zero");

endmodule

bind zeckendorf_decomposer zeck_checker u_zeck_checker (.*);
